@@ sv/blce_pkg.sv @@
package blce_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int ROUND_BOUND_DEF = 31;

    localparam int IN_W   = 17;
    localparam int OUT_W  = 18;
    localparam int Y_W    = 18;
    localparam int RL_W   = 5;
    localparam int TOL_W  = 16;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 18;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_START_LEVEL = 3'd0;
    localparam logic [IDX_W-1:0] REG_CTRL_A_X    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CTRL_A_Y    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CTRL_B_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CTRL_B_Y    = 3'd4;
    localparam logic [IDX_W-1:0] REG_END_LEVEL   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROUND_LIMIT = 3'd6;
    localparam logic [IDX_W-1:0] REG_TOLERANCE   = 3'd7;

    // Operand width of the shared multiplier.
    localparam int MUL_W = 32;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } blce_div_ctl_t;

endpackage

@@ sv/blce_if.sv @@
interface blce_in_if;
    logic                     valid;
    logic                     ready;
    logic [blce_pkg::IN_W-1:0] level_in;
    modport source (output valid, output level_in, input ready);
    modport sink (input valid, input level_in, output ready);
endinterface

interface blce_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [blce_pkg::OUT_W-1:0] level_out;
    modport source (output valid, output level_out, input ready);
    modport sink (input valid, input level_out, output ready);
endinterface

interface blce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [blce_pkg::IDX_W-1:0]  index;
    logic [blce_pkg::DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/bezier_level_curve_eval.sv @@
// Channel   Dir  Payload                    Accepted when
// in_ch     in   level_in (17b, Q1.16)      in_ch.valid && in_ch.ready
// out_ch    out  level_out (18b s, Q2.16)   out_ch.valid && out_ch.ready
// cfg_ch    in   index (3b), data (18b)     cfg_ch.valid && cfg_ch.ready
//
// One shared 32x32 multiplier runs a microcoded list of products. A full Newton
// round runs the multiply steps, a check step, the bit-serial division and an
// update step; a round that stops on a flat slope ends after the check. The
// final evaluation of By(t) runs its multiply steps and then a saturate step
// before the result is offered.
// Reset sets the configuration and sequencer registers and idles the block.
// The block takes no new level until its result is taken from out_ch.
module bezier_level_curve_eval #(
    parameter int FRAC_BITS   = blce_pkg::FRAC_BITS_DEF,
    parameter int ROUND_BOUND = blce_pkg::ROUND_BOUND_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    blce_in_if.sink       in_ch,
    blce_out_if.source    out_ch,
    blce_cfg_if.sink      cfg_ch
);
    localparam int W  = blce_pkg::MUL_W;
    localparam int PW = 2 * W;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    localparam int OMAX = (1 << (blce_pkg::OUT_W - 1)) - 1;
    localparam int RW = $clog2(ROUND_BOUND + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [blce_pkg::Y_W-1:0] y1_reg, y2_reg, y3_reg, y4_reg;
    logic [blce_pkg::IN_W-1:0]       x2_reg, x3_reg;
    logic [blce_pkg::RL_W-1:0]       rl_reg;
    logic [blce_pkg::TOL_W-1:0]      tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg  <= '0;
            x2_reg  <= 17'd21843;
            y2_reg  <= 18'sd21843;
            x3_reg  <= 17'd43693;
            y3_reg  <= 18'sd43693;
            y4_reg  <= 18'sd65536;
            rl_reg  <= 5'd8;
            tol_reg <= 16'd7;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.index)
                blce_pkg::REG_START_LEVEL: y1_reg  <= cfg_ch.data;
                blce_pkg::REG_CTRL_A_X:    x2_reg  <= cfg_ch.data[16:0];
                blce_pkg::REG_CTRL_A_Y:    y2_reg  <= cfg_ch.data;
                blce_pkg::REG_CTRL_B_X:    x3_reg  <= cfg_ch.data[16:0];
                blce_pkg::REG_CTRL_B_Y:    y3_reg  <= cfg_ch.data;
                blce_pkg::REG_END_LEVEL:   y4_reg  <= cfg_ch.data;
                blce_pkg::REG_ROUND_LIMIT: rl_reg  <= cfg_ch.data[4:0];
                blce_pkg::REG_TOLERANCE:   tol_reg <= cfg_ch.data[15:0];
                default: ;
            endcase
        end
    end
    assign cfg_ch.ready = 1'b1;

    function automatic logic signed [W-1:0] clamp_unit(input logic [blce_pkg::IN_W-1:0] v);
        clamp_unit = (W'(v) > ONE) ? ONE : W'(v);
    endfunction

    // Working registers, addressed by the micro program.
    localparam int NR = 16;
    localparam int AW = 4;
    localparam logic [AW-1:0] R_T = 4'd0, R_U = 4'd1, R_UU = 4'd2, R_TT = 4'd3,
        R_UT = 4'd4, R_A = 4'd5, R_B = 4'd6, R_C = 4'd7, R_X2 = 4'd8, R_X3 = 4'd9,
        R_DX = 4'd10, R_EX = 4'd11, R_Y = 4'd12, R_D = 4'd13, R_ONE = 4'd14,
        R_Z = 4'd15;

    logic signed [W-1:0] rf_reg [NR];
    logic signed [W-1:0] x_reg, acc_reg;
    logic [4:0]          pc_reg;
    logic [RW-1:0]       rnd_reg, rnd_lim_reg;
    logic signed [blce_pkg::OUT_W-1:0] res_reg;
    logic                final_reg;

    // Micro op: dst = (a*b)>>F, or accumulate k*(a*b)>>F.
    typedef struct packed {
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic [AW-1:0] dst;
        logic [2:0]    k;
        logic          wr;
        logic          acc;
        logic          clr;
    } uop_t;

    function automatic uop_t prog(input logic fin, input logic [4:0] pc);
        uop_t o;
        o = '{default: '0};
        if (!fin)
        begin
            case (pc)
                5'd0:  o = '{R_U,  R_U,  R_UU, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd1:  o = '{R_T,  R_T,  R_TT, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd2:  o = '{R_U,  R_T,  R_UT, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd3:  o = '{R_UU, R_T,  R_A,  3'd0, 1'b1, 1'b0, 1'b0};
                5'd4:  o = '{R_TT, R_U,  R_B,  3'd0, 1'b1, 1'b0, 1'b0};
                5'd5:  o = '{R_A,  R_X2, R_Z,  3'd3, 1'b0, 1'b1, 1'b1};
                5'd6:  o = '{R_B,  R_X3, R_Z,  3'd3, 1'b0, 1'b1, 1'b0};
                5'd7:  o = '{R_TT, R_T,  R_Z,  3'd1, 1'b0, 1'b1, 1'b0};
                5'd8:  o = '{R_UU, R_X2, R_Z,  3'd3, 1'b0, 1'b1, 1'b1};
                5'd9:  o = '{R_UT, R_DX, R_Z,  3'd6, 1'b0, 1'b1, 1'b0};
                default: o = '{R_TT, R_EX, R_Z, 3'd3, 1'b0, 1'b1, 1'b0};
            endcase
        end
        else
        begin
            case (pc)
                5'd0:  o = '{R_U,  R_U,  R_UU, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd1:  o = '{R_T,  R_T,  R_TT, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd2:  o = '{R_UU, R_U,  R_C,  3'd0, 1'b1, 1'b0, 1'b0};
                5'd3:  o = '{R_UU, R_T,  R_A,  3'd0, 1'b1, 1'b0, 1'b0};
                5'd4:  o = '{R_TT, R_U,  R_B,  3'd0, 1'b1, 1'b0, 1'b0};
                5'd5:  o = '{R_TT, R_T,  R_UT, 3'd0, 1'b1, 1'b0, 1'b0};
                5'd6:  o = '{R_C,  R_Y,  R_Z,  3'd1, 1'b0, 1'b1, 1'b1};
                5'd7:  o = '{R_A,  R_D,  R_Z,  3'd3, 1'b0, 1'b1, 1'b0};
                5'd8:  o = '{R_B,  R_X2, R_Z,  3'd3, 1'b0, 1'b1, 1'b0};
                default: o = '{R_UT, R_X3, R_Z, 3'd1, 1'b0, 1'b1, 1'b0};
            endcase
        end
        prog = o;
    endfunction

    uop_t                uop;
    logic signed [PW-1:0] prod;
    logic [PW-1:0]       pmag;
    logic signed [W-1:0] fm, fmk, bx_reg, r_mag, d_mag;
    logic                last_op;

    // Shared multiplier with truncation toward zero.
    assign uop  = prog(final_reg, pc_reg);
    assign prod = PW'(rf_reg[uop.a]) * PW'(rf_reg[uop.b]);
    assign pmag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    assign fm   = prod[PW-1] ? -W'(pmag >> FRAC_BITS) : W'(pmag >> FRAC_BITS);
    assign fmk  = W'(fm * W'(uop.k));
    assign last_op = final_reg ? (pc_reg == 5'd9) : (pc_reg == 5'd10);

    // Divider interface.
    blce_pkg::blce_div_ctl_t dctl;
    logic signed [W-1:0]     quo;
    logic signed [W-1:0]     t_new;

    blce_div #(.FRAC_BITS(FRAC_BITS), .W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dctl.start),
        .num   (bx_reg),
        .den   (acc_reg),
        .busy  (dctl.busy),
        .done  (dctl.done),
        .quo   (quo)
    );
    assign dctl.start = (state_reg == S_CHECK) && !(acc_reg == '0 ||
                        d_mag < W'(tol_reg));

    assign r_mag = bx_reg[W-1] ? -bx_reg : bx_reg;
    assign d_mag = acc_reg[W-1] ? -acc_reg : acc_reg;
    assign t_new = rf_reg[R_T] - quo;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            rnd_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        pc_reg    <= '0;
                        rnd_reg   <= '0;
                        final_reg <= (rl_reg == '0);
                        state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    if (!final_reg && pc_reg == 5'd7)
                        pc_reg <= pc_reg + 1'b1;
                    else if (last_op)
                    begin
                        pc_reg    <= '0;
                        state_reg <= final_reg ? S_SAT : S_CHECK;
                    end
                    else
                        pc_reg <= pc_reg + 1'b1;
                end
                S_CHECK:
                    if (dctl.start)
                        state_reg <= S_DIV;
                    else
                    begin
                        final_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                S_DIV:
                    if (dctl.done)
                        state_reg <= S_UPD;
                S_UPD:
                begin
                    rnd_reg   <= rnd_reg + 1'b1;
                    final_reg <= (r_mag < W'(tol_reg)) || (rnd_reg + 1'b1 == rnd_lim_reg);
                    state_reg <= S_MUL;
                end
                S_SAT:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            x_reg          <= clamp_unit(in_ch.level_in);
            rf_reg[R_T]    <= clamp_unit(in_ch.level_in);
            rf_reg[R_U]    <= ONE - clamp_unit(in_ch.level_in);
            rf_reg[R_X2]   <= clamp_unit(x2_reg);
            rf_reg[R_X3]   <= clamp_unit(x3_reg);
            rf_reg[R_DX]   <= clamp_unit(x3_reg) - clamp_unit(x2_reg);
            rf_reg[R_EX]   <= ONE - clamp_unit(x3_reg);
            rf_reg[R_Y]    <= W'(y1_reg);
            rf_reg[R_D]    <= W'(y2_reg);
            rf_reg[R_ONE]  <= ONE;
            rf_reg[R_Z]    <= '0;
            rnd_lim_reg    <= (int'(rl_reg) < ROUND_BOUND) ? RW'(rl_reg)
                                                           : RW'(ROUND_BOUND);
        end
        else if (state_reg == S_MUL)
        begin
            if (uop.wr)
                rf_reg[uop.dst] <= fm;
            if (uop.acc)
                acc_reg <= uop.clr ? fmk : acc_reg + fmk;
            // Residual is taken once Bx is complete.
            if (!final_reg && pc_reg == 5'd7)
                bx_reg <= acc_reg + fmk - x_reg;
            // Bring y3/y4 into the operand slots once x control points are done.
            if (final_reg && pc_reg == 5'd7)
            begin
                rf_reg[R_X2] <= W'(y3_reg);
                rf_reg[R_X3] <= W'(y4_reg);
            end
        end
        else if (state_reg == S_UPD)
        begin
            rf_reg[R_T] <= t_new[W-1] ? '0 : ((t_new > ONE) ? ONE : t_new);
            rf_reg[R_U] <= ONE - (t_new[W-1] ? '0 : ((t_new > ONE) ? ONE : t_new));
        end
        else if (state_reg == S_CHECK && !dctl.start)
        begin
            rf_reg[R_Y] <= W'(y1_reg);
            rf_reg[R_D] <= W'(y2_reg);
        end
        else if (state_reg == S_SAT)
        begin
            if (acc_reg > W'(OMAX))
                res_reg <= blce_pkg::OUT_W'(OMAX);
            else if (acc_reg < -W'(OMAX) - 1)
                res_reg <= blce_pkg::OUT_W'(-OMAX - 1);
            else
                res_reg <= acc_reg[blce_pkg::OUT_W-1:0];
        end
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = (state_reg == S_OUT);
    assign out_ch.level_out = res_reg;

    // Checks.
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        dctl.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside division state");
    a_rounds_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (rnd_reg < rnd_lim_reg))
        else $error("round count exceeded limit");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_reg)))
        else $error("result changed while stalled");
endmodule

@@ sv/blce_div.sv @@
module blce_div #(
    parameter int FRAC_BITS = blce_pkg::FRAC_BITS_DEF,
    parameter int W         = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                busy,
    output logic                done,
    output logic signed [W-1:0] quo
);
    localparam int NW  = W + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [NW-1:0] CAP = NW'(4) << FRAC_BITS;

    logic [NW-1:0]  rem_reg, rem_next;
    logic [NW-1:0]  q_reg, q_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [W-1:0]   d_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg, done_reg;
    logic [NW-1:0]  rem_sh;
    logic [NW-1:0]  q_cap;

    // One quotient bit per cycle, restoring.
    always_comb
    begin
        rem_sh   = {rem_reg[NW-2:0], n_reg[NW-1]};
        n_next   = {n_reg[NW-2:0], 1'b0};
        if (rem_sh >= NW'(d_reg))
        begin
            rem_next = rem_sh - NW'(d_reg);
            q_next   = {q_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            q_next   = {q_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= NW'(num[W-1] ? -num : num) << FRAC_BITS;
            d_reg   <= den[W-1] ? -den : den;
            neg_reg <= num[W-1] ^ den[W-1];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign q_cap = (q_reg > CAP) ? CAP : q_reg;
    assign quo   = neg_reg ? -W'(q_cap) : W'(q_cap);
    assign busy  = busy_reg;
    assign done  = done_reg;
endmodule

@@ tb/tb_bezier_level_curve_eval.sv @@
module tb_bezier_level_curve_eval;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 64'sd1 <<< blce_pkg::FRAC_BITS_DEF;
    localparam int LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    blce_in_if  in_ch ();
    blce_out_if out_ch ();
    blce_cfg_if cfg_ch ();

    bezier_level_curve_eval DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Predictor copy of the curve registers.
    longint p0y, p1x, p1y, p2x, p2y, p3y, rlim, tol;

    // Pending levels, pending register writes, expected curve values.
    logic [blce_pkg::IN_W-1:0]                      level_q[$];
    logic [blce_pkg::IDX_W+blce_pkg::DATA_W-1:0]    cfg_q[$];
    logic signed [blce_pkg::OUT_W-1:0]              curve_q[$];

    int  errors = 0;
    int  quiet = 0;
    int  idle_in_pct = 11;
    int  stall_pct = 11;
    bit  driving_done = 0;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint unit_clamp(longint v);
        if (v < 0) return 0;
        if (v > ONE) return ONE;
        return v;
    endfunction

    // Fixed-point product truncated toward zero.
    function automatic longint qmul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0 ? -p : p) >>> blce_pkg::FRAC_BITS_DEF;
        return p < 0 ? -m : m;
    endfunction

    // Saturating fixed-point quotient.
    function automatic longint qdiv(longint n, longint d);
        longint q;
        longint an;
        longint ad;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (an <<< blce_pkg::FRAC_BITS_DEF) / ad;
        if (q > 4 * ONE) q = 4 * ONE;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic signed [blce_pkg::OUT_W-1:0] curve_value(
        logic [blce_pkg::IN_W-1:0] lv);
        longint x, x2, x3, t, rounds, u, uu, tt, ut, bx, d, r, y;
        x = unit_clamp(longint'(lv));
        x2 = unit_clamp(p1x);
        x3 = unit_clamp(p2x);
        t = x;
        rounds = rlim < blce_pkg::ROUND_BOUND_DEF ? rlim : blce_pkg::ROUND_BOUND_DEF;
        for (longint i = 0; i < rounds; i++) begin
            u = ONE - t;
            uu = qmul(u, u);
            tt = qmul(t, t);
            ut = qmul(u, t);
            bx = 3 * qmul(qmul(uu, t), x2) + 3 * qmul(qmul(tt, u), x3) + qmul(tt, t);
            d = 3 * qmul(uu, x2) + 6 * qmul(ut, x3 - x2) + 3 * qmul(tt, ONE - x3);
            r = bx - x;
            if (d == 0 || (d < 0 ? -d : d) < tol) break;
            t = unit_clamp(t - qdiv(r, d));
            if ((r < 0 ? -r : r) < tol) break;
        end
        u = ONE - t;
        uu = qmul(u, u);
        tt = qmul(t, t);
        y = qmul(qmul(uu, u), p0y) + 3 * qmul(qmul(uu, t), p1y)
          + 3 * qmul(qmul(tt, u), p2y) + qmul(qmul(tt, t), p3y);
        if (y < -131072) y = -131072;
        if (y > 131071) y = 131071;
        return y[blce_pkg::OUT_W-1:0];
    endfunction

    function automatic longint sx18(logic [blce_pkg::DATA_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    // Apply an accepted register write to the predictor.
    task automatic apply_write(logic [blce_pkg::IDX_W-1:0] idx,
                               logic [blce_pkg::DATA_W-1:0] v);
        case (idx)
            blce_pkg::REG_START_LEVEL: p0y = sx18(v);
            blce_pkg::REG_CTRL_A_X:    p1x = longint'(v[16:0]);
            blce_pkg::REG_CTRL_A_Y:    p1y = sx18(v);
            blce_pkg::REG_CTRL_B_X:    p2x = longint'(v[16:0]);
            blce_pkg::REG_CTRL_B_Y:    p2y = sx18(v);
            blce_pkg::REG_END_LEVEL:   p3y = sx18(v);
            blce_pkg::REG_ROUND_LIMIT: rlim = longint'(v[4:0]);
            default:                   tol = longint'(v[15:0]);
        endcase
    endtask

    // Request driver for levels.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.level_in <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (level_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.level_in <= level_q.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Register write driver.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
        end else if (!cfg_ch.valid || cfg_ch.ready) begin
            if (cfg_q.size() > 0) begin
                cfg_ch.valid <= 1'b1;
                {cfg_ch.index, cfg_ch.data} <= cfg_q.pop_front();
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Output stall generator.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predict on accepted requests, check accepted results.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready)
                || (out_ch.valid && out_ch.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (cfg_ch.valid && cfg_ch.ready)
                apply_write(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                curve_q.push_back(curve_value(in_ch.level_in));
            if (out_ch.valid && out_ch.ready) begin
                if (curve_q.size() == 0)
                    report($sformatf("unexpected level_out %0d", out_ch.level_out));
                else if (out_ch.level_out !== curve_q[0]) begin
                    report($sformatf("level_out %0d, predicted %0d",
                                     out_ch.level_out, curve_q[0]));
                    void'(curve_q.pop_front());
                end else
                    void'(curve_q.pop_front());
            end
        end
    end

    task automatic write_reg(logic [blce_pkg::IDX_W-1:0] idx,
                             logic [blce_pkg::DATA_W-1:0] v);
        cfg_q.push_back({idx, v});
    endtask

    // Wait until every request is out and every result is back.
    task automatic drain();
        while (level_q.size() > 0 || cfg_q.size() > 0 || cfg_ch.valid
               || in_ch.valid || curve_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_regs(bit wild);
        write_reg(blce_pkg::REG_START_LEVEL, blce_pkg::DATA_W'($urandom));
        write_reg(blce_pkg::REG_CTRL_A_Y, blce_pkg::DATA_W'($urandom));
        write_reg(blce_pkg::REG_CTRL_B_Y, blce_pkg::DATA_W'($urandom));
        write_reg(blce_pkg::REG_END_LEVEL, blce_pkg::DATA_W'($urandom));
        if (wild) begin
            write_reg(blce_pkg::REG_CTRL_A_X, blce_pkg::DATA_W'($urandom_range(131071)));
            write_reg(blce_pkg::REG_CTRL_B_X, blce_pkg::DATA_W'($urandom_range(131071)));
            write_reg(blce_pkg::REG_TOLERANCE, blce_pkg::DATA_W'($urandom));
        end else begin
            write_reg(blce_pkg::REG_CTRL_A_X, blce_pkg::DATA_W'($urandom_range(65536)));
            write_reg(blce_pkg::REG_CTRL_B_X, blce_pkg::DATA_W'($urandom_range(65536)));
            write_reg(blce_pkg::REG_TOLERANCE, blce_pkg::DATA_W'($urandom_range(40)));
        end
        write_reg(blce_pkg::REG_ROUND_LIMIT, blce_pkg::DATA_W'($urandom_range(12)));
    endtask

    function automatic logic [blce_pkg::IN_W-1:0] rand_level();
        case ($urandom_range(9))
            0: return blce_pkg::IN_W'($urandom);
            1: return $urandom_range(1) ? 17'd0 : 17'd65536;
            default: return blce_pkg::IN_W'($urandom_range(65536));
        endcase
    endfunction

    // Stimulus.
    initial begin
        p0y = 0; p1x = 21843; p1y = 21843; p2x = 43693; p2y = 43693;
        p3y = 65536; rlim = 8; tol = 7;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and mid-range levels at reset settings.
        level_q.push_back(17'd0);
        level_q.push_back(17'd65536);
        level_q.push_back(17'h1FFFF);
        level_q.push_back(17'd65537);
        level_q.push_back(17'd32768);
        level_q.push_back(17'h15555);
        drain();

        // Directed: flat slope, zero tolerance, no rounds, overflow, max rounds.
        write_reg(blce_pkg::REG_CTRL_A_X, 18'd0);
        write_reg(blce_pkg::REG_CTRL_B_X, 18'd65536);
        write_reg(blce_pkg::REG_TOLERANCE, 18'd0);
        write_reg(blce_pkg::REG_START_LEVEL, 18'h1FFFF);
        write_reg(blce_pkg::REG_CTRL_A_Y, 18'h1FFFF);
        write_reg(blce_pkg::REG_CTRL_B_Y, 18'h20000);
        write_reg(blce_pkg::REG_END_LEVEL, 18'h20000);
        write_reg(blce_pkg::REG_ROUND_LIMIT, 18'd31);
        drain();
        level_q.push_back(17'd0);
        level_q.push_back(17'd65536);
        level_q.push_back(17'd1000);
        drain();
        write_reg(blce_pkg::REG_ROUND_LIMIT, 18'd0);
        write_reg(blce_pkg::REG_CTRL_A_X, 18'h1FFFF);
        write_reg(blce_pkg::REG_START_LEVEL, 18'h1FFFF);
        write_reg(blce_pkg::REG_CTRL_A_Y, 18'h1FFFF);
        write_reg(blce_pkg::REG_CTRL_B_Y, 18'h1FFFF);
        write_reg(blce_pkg::REG_END_LEVEL, 18'h1FFFF);
        write_reg(blce_pkg::REG_TOLERANCE, 18'hFFFF);
        drain();
        level_q.push_back(17'd20000);
        level_q.push_back(17'h1FFFF);
        drain();
        write_reg(blce_pkg::REG_ROUND_LIMIT, 18'd31);
        write_reg(blce_pkg::REG_CTRL_B_X, 18'd0);
        drain();
        level_q.push_back(17'd40000);
        level_q.push_back(17'd5);
        drain();

        // Random phases; the last ones run without idling.
        for (int ph = 0; ph < 17; ph++) begin
            if (ph >= 14) begin
                idle_in_pct = 0;
                stall_pct = 0;
            end else begin
                idle_in_pct = 11;
                stall_pct = 11;
            end
            random_regs(ph % 4 == 3);
            drain();
            for (int k = 0; k < 50; k++) level_q.push_back(rand_level());
            drain();
        end
        driving_done = 1;
    end

    // Watchdog and final verdict.
    initial begin
        wait (driving_done);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk) begin
        if (quiet >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

@@ sim.f @@
sv/blce_pkg.sv
sv/blce_if.sv
sv/blce_div.sv
sv/bezier_level_curve_eval.sv
tb/tb_bezier_level_curve_eval.sv
